// ----- hdl/amfr_pkg.sv -----
// Shared types and constants of the audio module frame receiver.
package amfr_pkg;

	// Frame geometry
	localparam int unsigned FRAME_LEN   = 10;
	localparam int unsigned POS_W       = 4;
	localparam int unsigned PAYLOAD_N   = 6;
	localparam int unsigned PAYLOAD_IW  = 3;
	localparam logic [POS_W-1:0] POS_START   = 4'd0;
	localparam logic [POS_W-1:0] POS_VERSION = 4'd1;
	localparam logic [POS_W-1:0] POS_LENGTH  = 4'd2;
	localparam logic [POS_W-1:0] POS_CMD     = 4'd3;
	localparam logic [POS_W-1:0] POS_SHORT_END = 4'd7;
	localparam logic [POS_W-1:0] POS_CK_LO   = 4'd8;
	localparam logic [POS_W-1:0] POS_END     = 4'(FRAME_LEN - 1);

	// Queue between framing and decode
	localparam int unsigned QUEUE_DEPTH = 2;

	// Configuration register indexes
	localparam logic [1:0] REG_START   = 2'd0;
	localparam logic [1:0] REG_VERSION = 2'd1;
	localparam logic [1:0] REG_LENGTH  = 2'd2;
	localparam logic [1:0] REG_END     = 2'd3;

	localparam logic [7:0] RST_START   = 8'h7E;
	localparam logic [7:0] RST_VERSION = 8'hFF;
	localparam logic [7:0] RST_LENGTH  = 8'h06;
	localparam logic [7:0] RST_END     = 8'hEF;

	// Message identifiers
	localparam logic [7:0] CMD_INSERTED   = 8'h3A;
	localparam logic [7:0] CMD_REMOVED    = 8'h3B;
	localparam logic [7:0] CMD_FIN_FIRST  = 8'h3C;
	localparam logic [7:0] CMD_FIN_LAST   = 8'h3E;
	localparam logic [7:0] CMD_INIT       = 8'h3F;
	localparam logic [7:0] CMD_ERROR      = 8'h40;
	localparam logic [7:0] CMD_ACK        = 8'h41;
	localparam logic [7:0] CMD_STATUS     = 8'h42;
	localparam logic [7:0] CMD_VOLUME     = 8'h43;
	localparam logic [7:0] CMD_SEQUENCE   = 8'h46;
	localparam logic [7:0] CMD_FCNT_FIRST = 8'h47;
	localparam logic [7:0] CMD_FCNT_LAST  = 8'h49;
	localparam logic [7:0] CMD_TRK_FIRST  = 8'h4B;
	localparam logic [7:0] CMD_TRK_LAST   = 8'h4D;
	localparam logic [7:0] CMD_FOLDER_TRK = 8'h4E;
	localparam logic [7:0] CMD_FOLDERS    = 8'h4F;

	// Event kinds
	localparam logic [3:0] EV_UNKNOWN    = 4'd0;
	localparam logic [3:0] EV_INSERTED   = 4'd1;
	localparam logic [3:0] EV_REMOVED    = 4'd2;
	localparam logic [3:0] EV_FINISHED   = 4'd3;
	localparam logic [3:0] EV_INIT       = 4'd4;
	localparam logic [3:0] EV_ERROR      = 4'd5;
	localparam logic [3:0] EV_ACK        = 4'd6;
	localparam logic [3:0] EV_STATUS     = 4'd7;
	localparam logic [3:0] EV_VOLUME     = 4'd8;
	localparam logic [3:0] EV_FILECOUNT  = 4'd12;
	localparam logic [3:0] EV_TRACK      = 4'd13;
	localparam logic [3:0] EV_FOLDER_TRK = 4'd14;
	localparam logic [3:0] EV_FOLDERS    = 4'd15;

	// Devices
	localparam logic [2:0] DEV_USB     = 3'd0;
	localparam logic [2:0] DEV_SD      = 3'd1;
	localparam logic [2:0] DEV_ONBOARD = 3'd3;
	localparam logic [2:0] DEV_NONE    = 3'd4;

	localparam logic [7:0] STATUS_HI_USB = 8'h01;
	localparam logic [7:0] STATUS_HI_SD  = 8'h02;
	localparam logic [7:0] STATE_MAX     = 8'h02;
	localparam logic [1:0] STATE_ASLEEP  = 2'd3;

	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] version_byte;
		logic [7:0] length_byte;
		logic [7:0] end_byte;
	} amfr_cfg_t;

	// One completed frame as handed from framing to decode
	typedef struct packed {
		logic [7:0] command;
		logic [7:0] feedback_byte;
		logic [7:0] param_hi;
		logic [7:0] param_lo;
		logic [7:0] ck_hi;
		logic [7:0] ck_lo;
		logic       full;
	} amfr_frame_t;

	typedef struct packed {
		logic [7:0]  command;
		logic [7:0]  feedback_byte;
		logic [15:0] param;
		logic        checksum_present;
		logic        frame_valid;
		logic [3:0]  event_kind;
		logic [2:0]  device;
		logic [3:0]  device_mask;
		logic [1:0]  module_state;
	} amfr_result_t;

	// Queue handshake seen by its producer and consumer
	typedef struct packed {
		logic full;
		logic empty;
	} amfr_qstat_t;

endpackage

// ----- hdl/amfr_front.sv -----
// Framing front end: tracks byte position, checks template bytes, stores payload.
module amfr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  amfr_pkg::amfr_cfg_t  cfg,
	input  logic                 byte_valid,
	input  logic [7:0]           rx_byte,
	output logic                 frm_push,
	output amfr_pkg::amfr_frame_t frm
);

	logic [amfr_pkg::POS_W-1:0] pos_q;
	logic [amfr_pkg::POS_W-1:0] pos;
	logic [amfr_pkg::POS_W-1:0] pos_nxt;
	logic [7:0]                 payload_q [amfr_pkg::PAYLOAD_N];
	logic                       in_payload;
	logic                       short_done;
	logic                       full_done;
	logic                       wr_payload;
	logic [7:0]                 expect_byte;
	logic [amfr_pkg::PAYLOAD_IW-1:0] wr_idx;

	// Treat an out-of-range position as the start
	assign pos = (pos_q > amfr_pkg::POS_END) ? amfr_pkg::POS_START : pos_q;
	assign in_payload = (pos >= amfr_pkg::POS_CMD) && (pos <= amfr_pkg::POS_CK_LO);
	assign wr_idx = amfr_pkg::PAYLOAD_IW'(pos - amfr_pkg::POS_CMD);

	always_comb begin
		unique case (pos)
			amfr_pkg::POS_START:   expect_byte = cfg.start_byte;
			amfr_pkg::POS_VERSION: expect_byte = cfg.version_byte;
			amfr_pkg::POS_LENGTH:  expect_byte = cfg.length_byte;
			default:               expect_byte = cfg.end_byte;
		endcase
	end

	// Decide next position and frame completion
	always_comb begin
		short_done = 1'b0;
		full_done  = 1'b0;
		wr_payload = 1'b0;
		if (in_payload) begin
			if (pos == amfr_pkg::POS_SHORT_END && rx_byte == cfg.end_byte) begin
				short_done = 1'b1;
				pos_nxt    = amfr_pkg::POS_START;
			end else begin
				wr_payload = 1'b1;
				pos_nxt    = pos + 1'b1;
			end
		end else if (rx_byte == expect_byte) begin
			if (pos == amfr_pkg::POS_END) begin
				full_done = 1'b1;
				pos_nxt   = amfr_pkg::POS_START;
			end else begin
				pos_nxt = pos + 1'b1;
			end
		end else begin
			// Resynchronize on a stray start byte
			pos_nxt = (rx_byte == cfg.start_byte) ? amfr_pkg::POS_VERSION
			                                      : amfr_pkg::POS_START;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= amfr_pkg::POS_START;
		end else if (byte_valid) begin
			pos_q <= pos_nxt;
		end
	end

	// Capture payload bytes at their positions
	always_ff @(posedge clk) begin
		for (int i = 0; i < amfr_pkg::PAYLOAD_N; i++) begin
			if (byte_valid && wr_payload && wr_idx == amfr_pkg::PAYLOAD_IW'(i)) begin
				payload_q[i] <= rx_byte;
			end
		end
	end

	assign frm_push          = byte_valid && (short_done || full_done);
	assign frm.command       = payload_q[0];
	assign frm.feedback_byte = payload_q[1];
	assign frm.param_hi      = payload_q[2];
	assign frm.param_lo      = payload_q[3];
	assign frm.ck_hi         = payload_q[4];
	assign frm.ck_lo         = payload_q[5];
	assign frm.full          = full_done;

endmodule

// ----- hdl/amfr_queue.sv -----
// Short register queue of completed frames between framing and decode.
module amfr_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  amfr_pkg::amfr_frame_t wr_frame,
	input  logic                  pop,
	output amfr_pkg::amfr_frame_t rd_frame,
	output amfr_pkg::amfr_qstat_t stat
);

	localparam int unsigned AW = $clog2(amfr_pkg::QUEUE_DEPTH);

	amfr_pkg::amfr_frame_t   mem_q [amfr_pkg::QUEUE_DEPTH];
	logic [AW-1:0]           wr_ptr_q;
	logic [AW-1:0]           rd_ptr_q;
	logic [AW:0]             count_q;
	logic                    do_push;
	logic                    do_pop;

	assign stat.full  = (count_q == (AW+1)'(amfr_pkg::QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rd_frame   = mem_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(amfr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(amfr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store the frame
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_frame;
		end
	end

endmodule

// ----- hdl/amfr_back.sv -----
// Decode back end: checksum verdict, event decode and the result register.
module amfr_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  amfr_pkg::amfr_cfg_t   cfg,
	input  amfr_pkg::amfr_frame_t frm,
	input  logic                  frm_avail,
	output logic                  frm_take,
	output amfr_pkg::amfr_result_t res,
	output logic                  res_valid,
	input  logic                  res_pop
);

	amfr_pkg::amfr_result_t res_q;
	amfr_pkg::amfr_result_t res_nxt;
	logic                   res_valid_q;
	logic [15:0]            sum16;
	logic [7:0]             cmd;
	logic [7:0]             hi;
	logic [7:0]             lo;
	logic [7:0]             diff;

	function automatic logic [2:0] dev_of(input logic [1:0] k);
		logic [2:0] d;
		case (k)
			2'd0:    d = amfr_pkg::DEV_USB;
			2'd1:    d = amfr_pkg::DEV_SD;
			2'd2:    d = amfr_pkg::DEV_ONBOARD;
			default: d = amfr_pkg::DEV_NONE;
		endcase
		return d;
	endfunction

	assign cmd = frm.command;
	assign hi  = frm.param_hi;
	assign lo  = frm.param_lo;

	// Two's-complement checksum over bytes 1..6 plus received checksum
	assign sum16 = 16'(cfg.version_byte) + 16'(cfg.length_byte) + 16'(cmd)
	             + 16'(frm.feedback_byte) + 16'(hi) + 16'(lo) + {frm.ck_hi, frm.ck_lo};

	// Decode the event
	always_comb begin
		res_nxt.command          = cmd;
		res_nxt.feedback_byte    = frm.feedback_byte;
		res_nxt.param            = {hi, lo};
		res_nxt.checksum_present = frm.full;
		res_nxt.frame_valid      = frm.full ? (sum16 == '0) : 1'b1;
		res_nxt.event_kind       = amfr_pkg::EV_UNKNOWN;
		res_nxt.device           = amfr_pkg::DEV_NONE;
		res_nxt.device_mask      = '0;
		res_nxt.module_state     = '0;
		diff = '0;
		unique case (cmd) inside
			amfr_pkg::CMD_INSERTED: begin
				res_nxt.event_kind  = amfr_pkg::EV_INSERTED;
				res_nxt.device_mask = {1'b0, lo[2:0]};
			end
			amfr_pkg::CMD_REMOVED: begin
				res_nxt.event_kind  = amfr_pkg::EV_REMOVED;
				res_nxt.device_mask = {1'b0, lo[2:0]};
			end
			[amfr_pkg::CMD_FIN_FIRST:amfr_pkg::CMD_FIN_LAST]: begin
				diff               = cmd - amfr_pkg::CMD_FIN_FIRST;
				res_nxt.event_kind = amfr_pkg::EV_FINISHED;
				res_nxt.device     = dev_of(diff[1:0]);
			end
			amfr_pkg::CMD_INIT: begin
				res_nxt.event_kind  = amfr_pkg::EV_INIT;
				res_nxt.device_mask = {lo[4], lo[2:0]};
			end
			amfr_pkg::CMD_ERROR: res_nxt.event_kind = amfr_pkg::EV_ERROR;
			amfr_pkg::CMD_ACK:   res_nxt.event_kind = amfr_pkg::EV_ACK;
			amfr_pkg::CMD_STATUS: begin
				res_nxt.event_kind = amfr_pkg::EV_STATUS;
				if (hi == amfr_pkg::STATUS_HI_USB) begin
					res_nxt.device = amfr_pkg::DEV_USB;
				end else if (hi == amfr_pkg::STATUS_HI_SD) begin
					res_nxt.device = amfr_pkg::DEV_SD;
				end
				res_nxt.module_state = (lo <= amfr_pkg::STATE_MAX) ? lo[1:0]
				                                                   : amfr_pkg::STATE_ASLEEP;
			end
			[amfr_pkg::CMD_VOLUME:amfr_pkg::CMD_SEQUENCE]: begin
				diff               = cmd - amfr_pkg::CMD_VOLUME;
				res_nxt.event_kind = amfr_pkg::EV_VOLUME + {2'b00, diff[1:0]};
			end
			[amfr_pkg::CMD_FCNT_FIRST:amfr_pkg::CMD_FCNT_LAST]: begin
				diff               = cmd - amfr_pkg::CMD_FCNT_FIRST;
				res_nxt.event_kind = amfr_pkg::EV_FILECOUNT;
				res_nxt.device     = dev_of(diff[1:0]);
			end
			[amfr_pkg::CMD_TRK_FIRST:amfr_pkg::CMD_TRK_LAST]: begin
				diff               = cmd - amfr_pkg::CMD_TRK_FIRST;
				res_nxt.event_kind = amfr_pkg::EV_TRACK;
				res_nxt.device     = dev_of(diff[1:0]);
			end
			amfr_pkg::CMD_FOLDER_TRK: res_nxt.event_kind = amfr_pkg::EV_FOLDER_TRK;
			amfr_pkg::CMD_FOLDERS:    res_nxt.event_kind = amfr_pkg::EV_FOLDERS;
			default: ;
		endcase
	end

	// Refill the result register when it is empty or being drained
	assign frm_take  = frm_avail && (!res_valid_q || res_pop);
	assign res       = res_q;
	assign res_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (frm_take) begin
			res_valid_q <= 1'b1;
		end else if (res_pop) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frm_take) begin
			res_q <= res_nxt;
		end
	end

endmodule

// ----- hdl/audio_module_frame_receiver.sv -----
// Audio module frame receiver: one byte per cycle in while full is low, one decoded result
// per completed frame. Each frame passes through the frame queue, then the result register.
// Framing and decode are parted by a two-entry frame queue.
// full rises only when two frames wait in the queue behind an unread result.
// Reset (arst_n low, asynchronous): position returns to the start, queue and result empty,
// template registers return to 0x7E, 0xFF, 0x06, 0xEF.
module audio_module_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  command,
	output logic [7:0]  feedback_byte,
	output logic [15:0] param,
	output logic        checksum_present,
	output logic        frame_valid,
	output logic [3:0]  event_kind,
	output logic [2:0]  device,
	output logic [3:0]  device_mask,
	output logic [1:0]  module_state,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	amfr_pkg::amfr_cfg_t    cfg_q;
	amfr_pkg::amfr_frame_t  frm_in;
	amfr_pkg::amfr_frame_t  frm_out;
	amfr_pkg::amfr_qstat_t  qstat;
	amfr_pkg::amfr_result_t res;
	logic                   frm_push;
	logic                   frm_take;
	logic                   res_valid;
	logic                   byte_take;

	assign cfg_ready = 1'b1;
	assign full      = qstat.full;
	assign byte_take = push && !qstat.full;

	// Write template registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte   <= amfr_pkg::RST_START;
			cfg_q.version_byte <= amfr_pkg::RST_VERSION;
			cfg_q.length_byte  <= amfr_pkg::RST_LENGTH;
			cfg_q.end_byte     <= amfr_pkg::RST_END;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				amfr_pkg::REG_START:   cfg_q.start_byte   <= cfg_data;
				amfr_pkg::REG_VERSION: cfg_q.version_byte <= cfg_data;
				amfr_pkg::REG_LENGTH:  cfg_q.length_byte  <= cfg_data;
				amfr_pkg::REG_END:     cfg_q.end_byte     <= cfg_data;
				default: ;
			endcase
		end
	end

	amfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.byte_valid (byte_take),
		.rx_byte    (rx_byte),
		.frm_push   (frm_push),
		.frm        (frm_in)
	);

	amfr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (frm_push),
		.wr_frame (frm_in),
		.pop      (frm_take),
		.rd_frame (frm_out),
		.stat     (qstat)
	);

	amfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.frm       (frm_out),
		.frm_avail (!qstat.empty),
		.frm_take  (frm_take),
		.res       (res),
		.res_valid (res_valid),
		.res_pop   (pop)
	);

	assign empty            = !res_valid;
	assign command          = res.command;
	assign feedback_byte    = res.feedback_byte;
	assign param            = res.param;
	assign checksum_present = res.checksum_present;
	assign frame_valid      = res.frame_valid;
	assign event_kind       = res.event_kind;
	assign device           = res.device;
	assign device_mask      = res.device_mask;
	assign module_state     = res.module_state;

	// A completed frame never meets a full queue
	a_no_lost_frame: assert property (@(posedge clk) disable iff (!arst_n)
		frm_push |-> !qstat.full) else $error("frame pushed into full queue");

	// Short frames always report valid
	a_short_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !checksum_present) |-> frame_valid) else $error("short frame marked invalid");

	// Module state is reported only with a status reply
	a_state_only_status: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && event_kind != amfr_pkg::EV_STATUS) |-> (module_state == 2'd0))
		else $error("module state outside status reply");

	// A taken result with nothing queued leaves the result side empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && qstat.empty) |=> empty) else $error("result repeated");

endmodule
